/* rtl/qalu_pkg.sv */
// qalu_pkg: shared widths, pipeline depths, types and the saturation helper
// for the quaternion unit; no dependencies
`default_nettype none

package qalu_pkg;

  localparam int DATA_W = 32;          // q16.16 component
  localparam int LANES  = 4;           // x, y, z, w
  localparam int VEC_N  = 3;           // x, y, z
  localparam int PROD_W = 64;          // one 32x32 product
  localparam int PSUM_W = 66;          // sum of four products
  localparam int MAT_W  = 66;          // rotation matrix entry, 1.0 = 2^32
  localparam int MLO_W  = 33;          // low slice of a matrix entry
  localparam int PP_W   = 66;          // matrix slice times vector
  localparam int RSUM_W = 68;          // three partial products
  localparam int ACC_W  = 100;         // full rotation accumulator
  localparam int CLIP_W = 68;          // input of the saturation helper
  localparam int SQ_W   = 65;          // sum of squares
  localparam int ROOT_W = 33;          // integer square root bits
  localparam int REM_W  = 2 * ROOT_W + 1;
  localparam int QUO_W  = 17;          // normalized magnitude bits
  localparam int NUM_W  = DATA_W + QUO_W + 1;
  localparam int DEN_W  = ROOT_W + 1;

  localparam int ARITH_LAT = 6;                          // product and rotate done
  localparam int NORM_LAT  = ROOT_W + 1 + QUO_W;         // sqrt, prep, divide
  localparam int PIPE_LAT  = 2 + NORM_LAT + 1;           // input to output register
  localparam int DLY_N     = PIPE_LAT - 1 - ARITH_LAT;

  localparam logic signed [PSUM_W-1:0] PROD_HALF = PSUM_W'(1) << 15;
  localparam logic signed [ACC_W-1:0]  ROT_HALF  = ACC_W'(1) << 31;
  localparam logic signed [MAT_W-1:0]  MAT_ONE   = MAT_W'(1) << 32;
  localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [1:0] {
    KIND_PRODUCT     = 2'd0,
    KIND_ROTATE      = 2'd1,
    KIND_CONJ_ROTATE = 2'd2,
    KIND_NORMALIZE   = 2'd3
  } kind_e;

  typedef struct packed {
    logic [LANES-1:0][DATA_W-1:0] comp;
    logic                         sat;
  } res_t;

  typedef struct packed {
    logic [LANES-1:0][DATA_W-1:0] comp;
    logic                         zero;
  } norm_res_t;

  typedef struct packed {
    logic [DATA_W-1:0] val;
    logic              sat;
  } clip_t;

  // clip a wide signed value into the 32-bit range
  function automatic clip_t clip32(input logic signed [CLIP_W-1:0] v);
    clip_t                      r;
    logic [CLIP_W-DATA_W:0]     hi;
    hi = v[CLIP_W-1:DATA_W-1];
    if (hi == '0 || hi == '1) begin
      r.val = v[DATA_W-1:0];
      r.sat = 1'b0;
    end else begin
      r.val = v[CLIP_W-1] ? SAT_MIN : SAT_MAX;
      r.sat = 1'b1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/qalu_if.sv */
// qalu_in_if and qalu_out_if: valid/ready channels of the quaternion unit
// depends on qalu_pkg
`default_nettype none

interface qalu_in_if;
  logic                                valid;
  logic                                ready;
  qalu_pkg::kind_e                     kind;
  logic signed [qalu_pkg::DATA_W-1:0]  quat_x;
  logic signed [qalu_pkg::DATA_W-1:0]  quat_y;
  logic signed [qalu_pkg::DATA_W-1:0]  quat_z;
  logic signed [qalu_pkg::DATA_W-1:0]  quat_w;
  logic signed [qalu_pkg::DATA_W-1:0]  second_x;
  logic signed [qalu_pkg::DATA_W-1:0]  second_y;
  logic signed [qalu_pkg::DATA_W-1:0]  second_z;
  logic signed [qalu_pkg::DATA_W-1:0]  second_w;

  modport source (
    output valid, kind, quat_x, quat_y, quat_z, quat_w,
    output second_x, second_y, second_z, second_w,
    input  ready
  );
  modport sink (
    input  valid, kind, quat_x, quat_y, quat_z, quat_w,
    input  second_x, second_y, second_z, second_w,
    output ready
  );
endinterface

interface qalu_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [qalu_pkg::DATA_W-1:0]  res_x;
  logic signed [qalu_pkg::DATA_W-1:0]  res_y;
  logic signed [qalu_pkg::DATA_W-1:0]  res_z;
  logic signed [qalu_pkg::DATA_W-1:0]  res_w;
  logic                                saturated;
  logic                                zero_length;

  modport source (
    output valid, res_x, res_y, res_z, res_w, saturated, zero_length,
    input  ready
  );
  modport sink (
    input  valid, res_x, res_y, res_z, res_w, saturated, zero_length,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/qalu_norm.sv */
// qalu_norm: pipelined integer square root and four dividers for normalize
// depends on qalu_pkg
`default_nettype none

module qalu_norm (
  input  logic                                             clk_i,
  input  logic                                             en_i,
  input  logic [qalu_pkg::SQ_W-1:0]                        sq_sum_i,
  input  logic [qalu_pkg::LANES-1:0][qalu_pkg::DATA_W-1:0] mag_i,
  input  logic [qalu_pkg::LANES-1:0]                       neg_i,
  output qalu_pkg::norm_res_t                              res_o
);
  import qalu_pkg::*;

  // square root, one result bit per stage
  logic [REM_W-1:0]             srem_q  [ROOT_W];
  logic [ROOT_W-1:0]            root_q  [ROOT_W];
  logic [LANES-1:0][DATA_W-1:0] smag_q  [ROOT_W];
  logic [LANES-1:0]             sneg_q  [ROOT_W];

  for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
    localparam int K = ROOT_W - 1 - i;
    logic [REM_W-1:0]             rem_in;
    logic [REM_W-1:0]             trial;
    logic [ROOT_W-1:0]            root_in;
    logic [LANES-1:0][DATA_W-1:0] mag_in;
    logic [LANES-1:0]             neg_in;

    if (i == 0) begin : g_head
      assign rem_in  = REM_W'(sq_sum_i);
      assign root_in = '0;
      assign mag_in  = mag_i;
      assign neg_in  = neg_i;
    end else begin : g_body
      assign rem_in  = srem_q[i-1];
      assign root_in = root_q[i-1];
      assign mag_in  = smag_q[i-1];
      assign neg_in  = sneg_q[i-1];
    end

    // (root + 2^k)^2 - root^2
    assign trial = (REM_W'(root_in) << (K + 1)) + (REM_W'(1) << (2 * K));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_in >= trial) begin
          srem_q[i] <= rem_in - trial;
          root_q[i] <= root_in | (ROOT_W'(1) << K);
        end else begin
          srem_q[i] <= rem_in;
          root_q[i] <= root_in;
        end
        smag_q[i] <= mag_in;
        sneg_q[i] <= neg_in;
      end
    end
  end

  // numerator 2*|a|*2^16 + L, denominator 2*L: round half away from zero
  logic [LANES-1:0][NUM_W-1:0] num_q;
  logic [DEN_W-1:0]            den_q;
  logic [LANES-1:0]            pneg_q;
  logic                        pzero_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < LANES; l++) begin
        num_q[l] <= (NUM_W'(smag_q[ROOT_W-1][l]) << QUO_W) + NUM_W'(root_q[ROOT_W-1]);
      end
      den_q   <= {root_q[ROOT_W-1], 1'b0};
      pneg_q  <= sneg_q[ROOT_W-1];
      pzero_q <= (root_q[ROOT_W-1] == '0);
    end
  end

  // restoring division, one quotient bit per stage on all lanes
  logic [LANES-1:0][NUM_W-1:0] drem_q  [QUO_W];
  logic [LANES-1:0][QUO_W-1:0] quo_q   [QUO_W];
  logic [DEN_W-1:0]            dden_q  [QUO_W];
  logic [LANES-1:0]            dneg_q  [QUO_W];
  logic                        dzero_q [QUO_W];

  for (genvar d = 0; d < QUO_W; d++) begin : g_div
    localparam int J = QUO_W - 1 - d;
    logic [LANES-1:0][NUM_W-1:0] r_in;
    logic [LANES-1:0][QUO_W-1:0] q_in;
    logic [DEN_W-1:0]            den_in;
    logic [LANES-1:0]            neg_in;
    logic                        zero_in;
    logic [NUM_W-1:0]            step;

    if (d == 0) begin : g_head
      assign r_in    = num_q;
      assign q_in    = '0;
      assign den_in  = den_q;
      assign neg_in  = pneg_q;
      assign zero_in = pzero_q;
    end else begin : g_body
      assign r_in    = drem_q[d-1];
      assign q_in    = quo_q[d-1];
      assign den_in  = dden_q[d-1];
      assign neg_in  = dneg_q[d-1];
      assign zero_in = dzero_q[d-1];
    end

    assign step = NUM_W'(den_in) << J;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int l = 0; l < LANES; l++) begin
          if (r_in[l] >= step) begin
            drem_q[d][l] <= r_in[l] - step;
            quo_q[d][l]  <= q_in[l] | (QUO_W'(1) << J);
          end else begin
            drem_q[d][l] <= r_in[l];
            quo_q[d][l]  <= q_in[l];
          end
        end
        dden_q[d]  <= den_in;
        dneg_q[d]  <= neg_in;
        dzero_q[d] <= zero_in;
      end
    end
  end

  always_comb begin
    res_o.zero = dzero_q[QUO_W-1];
    for (int l = 0; l < LANES; l++) begin
      if (dzero_q[QUO_W-1]) begin
        res_o.comp[l] = '0;
      end else if (dneg_q[QUO_W-1][l]) begin
        res_o.comp[l] = -DATA_W'(quo_q[QUO_W-1][l]);
      end else begin
        res_o.comp[l] = DATA_W'(quo_q[QUO_W-1][l]);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/quaternion_alu.sv */
// quaternion_alu: q16.16 quaternion product, rotation and normalize, fully pipelined
// one beat per cycle sustained while the output is not stalled
// the normalize path sets the depth: 33 square root steps and 17 divide steps
// product and rotate finish after 6 stages and wait in a delay line to stay in order
// a stalled output freezes every stage; reset clears only the stage valid bits
// depends on qalu_pkg, qalu_if and qalu_norm
`default_nettype none

module quaternion_alu (
  input  logic       clk_i,
  input  logic       rst_ni,
  qalu_in_if.sink    in_i,
  qalu_out_if.source out_o
);
  import qalu_pkg::*;

  typedef struct packed {
    kind_e kind;
    res_t  res;
  } tag_t;

  // one enable for the whole pipe: move when the output slot is free or taken
  logic                adv;
  logic [PIPE_LAT:1]   vld_q;

  assign adv        = !vld_q[PIPE_LAT] || out_o.ready;
  assign in_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[PIPE_LAT-1:1], in_i.valid};
    end
  end

  // operand views
  logic signed [DATA_W-1:0] qa [LANES];
  logic signed [DATA_W-1:0] qb [LANES];

  assign qa[0] = in_i.quat_x;
  assign qa[1] = in_i.quat_y;
  assign qa[2] = in_i.quat_z;
  assign qa[3] = in_i.quat_w;
  assign qb[0] = in_i.second_x;
  assign qb[1] = in_i.second_y;
  assign qb[2] = in_i.second_z;
  assign qb[3] = in_i.second_w;

  // stage 1: all 32x32 products
  logic signed [PROD_W-1:0]     ab1_q [LANES][LANES];   // a[i]*b[j] for the hamilton product
  logic signed [PROD_W-1:0]     sq1_q [LANES];          // squares, shared by rotate and normalize
  logic signed [PROD_W-1:0]     xy1_q, xz1_q, yz1_q, xw1_q, yw1_q, zw1_q;
  logic signed [DATA_W-1:0]     v1_q  [VEC_N];
  logic [LANES-1:0][DATA_W-1:0] mag1_q;
  logic [LANES-1:0]             neg1_q;
  kind_e                        kind1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < LANES; i++) begin
        for (int j = 0; j < LANES; j++) begin
          ab1_q[i][j] <= qa[i] * qb[j];
        end
        sq1_q[i]  <= qa[i] * qa[i];
        neg1_q[i] <= qa[i][DATA_W-1];
        mag1_q[i] <= qa[i][DATA_W-1] ? -qa[i] : qa[i];
      end
      xy1_q <= qa[0] * qa[1];
      xz1_q <= qa[0] * qa[2];
      yz1_q <= qa[1] * qa[2];
      xw1_q <= qa[0] * qa[3];
      yw1_q <= qa[1] * qa[3];
      zw1_q <= qa[2] * qa[3];
      for (int c = 0; c < VEC_N; c++) begin
        v1_q[c] <= qb[c];
      end
      kind1_q <= in_i.kind;
    end
  end

  // stage 2: product sums, rotation matrix, sum of squares
  logic signed [MAT_W-1:0] exx, eyy, ezz, exy, exz, eyz, exw, eyw, ezw;
  logic                    conj1;

  // conjugate rotation flips the sign of every term that holds w
  assign conj1 = (kind1_q == KIND_CONJ_ROTATE);
  assign exx   = MAT_W'(sq1_q[0]);
  assign eyy   = MAT_W'(sq1_q[1]);
  assign ezz   = MAT_W'(sq1_q[2]);
  assign exy   = MAT_W'(xy1_q);
  assign exz   = MAT_W'(xz1_q);
  assign eyz   = MAT_W'(yz1_q);
  assign exw   = conj1 ? -MAT_W'(xw1_q) : MAT_W'(xw1_q);
  assign eyw   = conj1 ? -MAT_W'(yw1_q) : MAT_W'(yw1_q);
  assign ezw   = conj1 ? -MAT_W'(zw1_q) : MAT_W'(zw1_q);

  logic signed [PSUM_W-1:0]     psum2_q [LANES];
  logic signed [MAT_W-1:0]      mat2_q  [VEC_N][VEC_N];
  logic signed [DATA_W-1:0]     v2_q    [VEC_N];
  logic [SQ_W-1:0]              sqs2_q;
  logic [LANES-1:0][DATA_W-1:0] mag2_q;
  logic [LANES-1:0]             neg2_q;
  kind_e                        kind2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // hamilton product, component by component
      psum2_q[0] <= PSUM_W'(ab1_q[3][0]) + PSUM_W'(ab1_q[0][3])
                  + PSUM_W'(ab1_q[1][2]) - PSUM_W'(ab1_q[2][1]);
      psum2_q[1] <= PSUM_W'(ab1_q[3][1]) - PSUM_W'(ab1_q[0][2])
                  + PSUM_W'(ab1_q[1][3]) + PSUM_W'(ab1_q[2][0]);
      psum2_q[2] <= PSUM_W'(ab1_q[3][2]) + PSUM_W'(ab1_q[0][1])
                  - PSUM_W'(ab1_q[1][0]) + PSUM_W'(ab1_q[2][3]);
      psum2_q[3] <= PSUM_W'(ab1_q[3][3]) - PSUM_W'(ab1_q[0][0])
                  - PSUM_W'(ab1_q[1][1]) - PSUM_W'(ab1_q[2][2]);
      // rotation matrix with 1.0 at bit 32
      mat2_q[0][0] <= MAT_ONE - ((eyy + ezz) <<< 1);
      mat2_q[0][1] <= (exy - ezw) <<< 1;
      mat2_q[0][2] <= (exz + eyw) <<< 1;
      mat2_q[1][0] <= (exy + ezw) <<< 1;
      mat2_q[1][1] <= MAT_ONE - ((ezz + exx) <<< 1);
      mat2_q[1][2] <= (eyz - exw) <<< 1;
      mat2_q[2][0] <= (exz - eyw) <<< 1;
      mat2_q[2][1] <= (eyz + exw) <<< 1;
      mat2_q[2][2] <= MAT_ONE - ((exx + eyy) <<< 1);
      sqs2_q <= SQ_W'(unsigned'(sq1_q[0])) + SQ_W'(unsigned'(sq1_q[1]))
              + SQ_W'(unsigned'(sq1_q[2])) + SQ_W'(unsigned'(sq1_q[3]));
      for (int c = 0; c < VEC_N; c++) begin
        v2_q[c] <= v1_q[c];
      end
      mag2_q  <= mag1_q;
      neg2_q  <= neg1_q;
      kind2_q <= kind1_q;
    end
  end

  // stage 3: product rounding, matrix slices times vector
  logic signed [PSUM_W-1:0] prnd  [LANES];
  clip_t                    pclip [LANES];
  res_t                     pr3_d;

  always_comb begin
    pr3_d.sat = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      prnd[i]       = psum2_q[i] + PROD_HALF;
      pclip[i]      = clip32(CLIP_W'(prnd[i] >>> 16));
      pr3_d.comp[i] = pclip[i].val;
      pr3_d.sat     = pr3_d.sat | pclip[i].sat;
    end
  end

  logic signed [PP_W-1:0] plo3_q [VEC_N][VEC_N];
  logic signed [PP_W-1:0] phi3_q [VEC_N][VEC_N];
  res_t                   pr3_q;
  kind_e                  kind3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < VEC_N; r++) begin
        for (int c = 0; c < VEC_N; c++) begin
          plo3_q[r][c] <= signed'({1'b0, mat2_q[r][c][MLO_W-1:0]}) * v2_q[c];
          phi3_q[r][c] <= signed'(mat2_q[r][c][MAT_W-1:MLO_W]) * v2_q[c];
        end
      end
      pr3_q   <= pr3_d;
      kind3_q <= kind2_q;
    end
  end

  // stage 4: row sums of low and high slices
  logic signed [RSUM_W-1:0] rsl4_q [VEC_N];
  logic signed [RSUM_W-1:0] rsh4_q [VEC_N];
  res_t                     pr4_q;
  kind_e                    kind4_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < VEC_N; r++) begin
        rsl4_q[r] <= RSUM_W'(plo3_q[r][0]) + RSUM_W'(plo3_q[r][1]) + RSUM_W'(plo3_q[r][2]);
        rsh4_q[r] <= RSUM_W'(phi3_q[r][0]) + RSUM_W'(phi3_q[r][1]) + RSUM_W'(phi3_q[r][2]);
      end
      pr4_q   <= pr3_q;
      kind4_q <= kind3_q;
    end
  end

  // stage 5: join the slices and add the rounding half
  logic signed [ACC_W-1:0] acc5_q [VEC_N];
  res_t                    pr5_q;
  kind_e                   kind5_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < VEC_N; r++) begin
        acc5_q[r] <= (ACC_W'(rsh4_q[r]) <<< MLO_W) + ACC_W'(rsl4_q[r]) + ROT_HALF;
      end
      pr5_q   <= pr4_q;
      kind5_q <= kind4_q;
    end
  end

  // stage 6: rotation saturation, pick the arithmetic result
  clip_t rclip [VEC_N];
  res_t  rot_d;
  tag_t  ar6_d;

  always_comb begin
    rot_d.sat = 1'b0;
    for (int r = 0; r < VEC_N; r++) begin
      rclip[r]      = clip32(CLIP_W'(acc5_q[r] >>> 32));
      rot_d.comp[r] = rclip[r].val;
      rot_d.sat     = rot_d.sat | rclip[r].sat;
    end
    rot_d.comp[3] = '0;
    ar6_d.kind    = kind5_q;
    ar6_d.res     = (kind5_q == KIND_PRODUCT) ? pr5_q : rot_d;
  end

  tag_t ar6_q;
  tag_t dl_q [DLY_N];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ar6_q    <= ar6_d;
      dl_q[0]  <= ar6_q;
      for (int k = 1; k < DLY_N; k++) begin
        dl_q[k] <= dl_q[k-1];
      end
    end
  end

  // normalize path runs beside the delay line
  norm_res_t norm_res;

  qalu_norm u_norm (
    .clk_i    (clk_i),
    .en_i     (adv),
    .sq_sum_i (sqs2_q),
    .mag_i    (mag2_q),
    .neg_i    (neg2_q),
    .res_o    (norm_res)
  );

  // output register
  res_t out_res_q;
  logic out_zero_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (dl_q[DLY_N-1].kind == KIND_NORMALIZE) begin
        out_res_q.comp <= norm_res.comp;
        out_res_q.sat  <= 1'b0;
        out_zero_q     <= norm_res.zero;
      end else begin
        out_res_q  <= dl_q[DLY_N-1].res;
        out_zero_q <= 1'b0;
      end
    end
  end

  assign out_o.valid       = vld_q[PIPE_LAT];
  assign out_o.res_x       = out_res_q.comp[0];
  assign out_o.res_y       = out_res_q.comp[1];
  assign out_o.res_z       = out_res_q.comp[2];
  assign out_o.res_w       = out_res_q.comp[3];
  assign out_o.saturated   = out_res_q.sat;
  assign out_o.zero_length = out_zero_q;

  // a zero-length normalize beat carries zeros and no clipping
  a_zero_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.zero_length |->
      out_o.res_x == '0 && out_o.res_y == '0 && out_o.res_z == '0 &&
      out_o.res_w == '0 && !out_o.saturated)
    else $error("zero_length beat with nonzero payload");

  // a clipped beat must show at least one rail value
  a_sat_rail : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.saturated |->
      out_o.res_x == SAT_MAX || out_o.res_x == SAT_MIN ||
      out_o.res_y == SAT_MAX || out_o.res_y == SAT_MIN ||
      out_o.res_z == SAT_MAX || out_o.res_z == SAT_MIN ||
      out_o.res_w == SAT_MAX || out_o.res_w == SAT_MIN)
    else $error("saturated beat without a rail value");

  // a held output beat freezes the whole pipe, so no new beat may enter
  a_stall_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |-> !in_i.ready)
    else $error("input accepted while output stalled");

endmodule

`default_nettype wire
